[rtl/core/sgr_pkg.sv]
// Package for the stream group reverser.
// Transfer payload types, register map and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned GS_W   = 5;

   localparam logic        REG_GROUP_SIZE = 1'b0;
   localparam logic [GS_W-1:0] GS_RESET   = 5'd1;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     out_last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/sgr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds until the next read enable; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sgr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/sgr_ctrl.sv]
// Group sequencer: stores values into the group RAM and drains held groups,
// reversed or in order. Uses sgr_pkg for widths; drives sgr_ram ports.
`timescale 1ns / 1ps
`default_nettype none

module sgr_ctrl #(
   parameter int unsigned MAX_GROUP = 16,
   localparam int unsigned AW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
   localparam int unsigned CW   = $clog2(MAX_GROUP + 1),
   localparam int unsigned CMPW = (CW > sgr_pkg::GS_W) ? CW : sgr_pkg::GS_W
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [sgr_pkg::GS_W-1:0] group_size,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_is_last,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type       state_ff,   state_in;
   logic [AW-1:0]   held_ff,    held_in;
   logic [AW-1:0]   addr_ff,    addr_in;
   logic [CW-1:0]   remain_ff,  remain_in;
   logic            reverse_ff, reverse_in;
   logic            last_ff,    last_in;
   logic            valid_ff,   valid_in;
   logic            olast_ff,   olast_in;

   logic            req_accept;
   logic            rsp_accept;
   logic            issue;
   logic [CW-1:0]   count_n;
   logic [CMPW-1:0] gs_ext;
   logic [CMPW-1:0] k_eff;
   logic            full;

   assign gs_ext = CMPW'(group_size);

   always_comb begin
      priority if (group_size == '0) begin
         k_eff = CMPW'(1);
      end else if (gs_ext > CMPW'(MAX_GROUP)) begin
         k_eff = CMPW'(MAX_GROUP);
      end else begin
         k_eff = gs_ext;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = valid_ff && !rsp_stall;
   assign issue      = (state_ff == ST_DRAIN) && (!valid_ff || rsp_accept);
   assign count_n    = CW'(held_ff) + CW'(1);
   assign full       = CMPW'(count_n) >= k_eff;

   assign wr_en   = req_accept;
   assign wr_addr = held_ff;
   assign rd_en   = issue;
   assign rd_addr = addr_ff;

   always_comb begin
      state_in   = state_ff;
      held_in    = held_ff;
      addr_in    = addr_ff;
      remain_in  = remain_ff;
      reverse_in = reverse_ff;
      last_in    = last_ff;
      olast_in   = olast_ff;
      valid_in   = rsp_accept ? 1'b0 : valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (full || req_is_last) begin
                  state_in   = ST_DRAIN;
                  held_in    = '0;
                  remain_in  = count_n;
                  reverse_in = full;
                  last_in    = req_is_last;
                  addr_in    = full ? held_ff : '0;
               end else begin
                  held_in = AW'(count_n);
               end
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               valid_in  = 1'b1;
               olast_in  = last_ff && (remain_ff == CW'(1));
               remain_in = remain_ff - CW'(1);
               addr_in   = reverse_ff ? addr_ff - AW'(1) : addr_ff + AW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
      addr_ff    <= addr_in;
      remain_ff  <= remain_in;
      reverse_ff <= reverse_in;
      last_ff    <= last_in;
      olast_ff   <= olast_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_last  = olast_ff;

endmodule

`default_nettype wire

[rtl/core/stream_group_reverser_unit.sv]
// Stream group reverser top level: register port, group RAM and sequencer.
// Depends on sgr_pkg, sgr_ram and sgr_ctrl.
// Order: an item that closes a group moves the sequencer to drain; each result is
// read into the RAM read register, one per cycle while rsp_stall is low.
// Input: req_stall holds new items while a held group drains.
// Reset: group_size returns to 1, held count to 0; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stream_group_reverser_unit #(
   parameter int unsigned MAX_GROUP = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sgr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sgr_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [sgr_pkg::GS_W-1:0]  group_size_ff;
   logic [sgr_pkg::GS_W-1:0]  group_size_in;
   logic                      reg_sel;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [sgr_pkg::DATA_W-1:0] rd_data;
   logic                      rsp_last;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == sgr_pkg::REG_GROUP_SIZE);

   always_comb begin
      group_size_in = group_size_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         group_size_in = pwdata[sgr_pkg::GS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= sgr_pkg::GS_RESET;
      end else begin
         group_size_ff <= group_size_in;
      end
   end

   assign prdata = reg_sel ? 32'(group_size_ff) : '0;

   sgr_ram #(
      .WIDTH (sgr_pkg::DATA_W),
      .DEPTH (MAX_GROUP)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sgr_ctrl #(
      .MAX_GROUP (MAX_GROUP)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .group_size  (group_size_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_is_last (req_data.is_last),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_last    (rsp_last)
   );

   assign rsp_data = {rd_data, rsp_last};

endmodule

`default_nettype wire
